[design/tsmq_pkg.sv]
`default_nettype none
// ============================================================================
// Timestamp merge of two queues: shared package
// Field widths, record layout, request kinds and response status codes.
// ============================================================================
package tsmq_pkg;

   localparam int STAMP_W  = 64;
   localparam int PROC_W   = 32;
   localparam int TAG_W    = 16;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 2;

   // Request kinds.
   localparam logic [KIND_W-1:0] KIND_PUSH_EVENT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PUSH_STACK = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PULL       = 2'd2;
   localparam logic [KIND_W-1:0] KIND_UNUSED     = 2'd3;

   // Response status codes.
   localparam logic [STATUS_W-1:0] STATUS_PUSH_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_PUSH_DROP = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_PULL_DATA = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_PULL_DONE = 2'd3;

   // One queued record, as stored in either queue memory.
   typedef struct packed {
      logic [STAMP_W-1:0] stamp;
      logic [PROC_W-1:0]  proc_id;
      logic [TAG_W-1:0]   tag;
   } rec_type;

endpackage : tsmq_pkg
`default_nettype wire

[design/timestamp_merge_two_queues_unit.sv]
`default_nettype none
// A push or pull response is registered from the alignment state, after the merge step;
// kind 3 is accepted while idle and gives no response.
// A new request is not taken until the last one has passed the accept, the merge
// step on the head records and the alignment check on the re-read heads.
// A response still held by stall keeps the next one in its alignment cycle.
// Reset empties both queues and clears control state; queue storage is not cleared.
// ============================================================================
// Timestamp merge of two queues
// Two circular record queues (events and call stacks) in synchronous memories,
// with a pull that merges their heads by timestamp.
// ============================================================================
module timestamp_merge_two_queues_unit #(
   parameter int QUEUE_DEPTH = 64
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // Request channel.
   input  wire logic                           req_valid,
   output      logic                           req_stall,
   input  wire logic [tsmq_pkg::KIND_W-1:0]    req_kind,
   input  wire logic [tsmq_pkg::STAMP_W-1:0]   req_stamp,
   input  wire logic [tsmq_pkg::PROC_W-1:0]    req_proc_id,
   input  wire logic [tsmq_pkg::TAG_W-1:0]     req_tag,
   // Response channel.
   output      logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   output      logic [tsmq_pkg::STATUS_W-1:0]  rsp_status,
   output      logic                           rsp_event_valid,
   output      logic [tsmq_pkg::TAG_W-1:0]     rsp_event_tag,
   output      logic [tsmq_pkg::STAMP_W-1:0]   rsp_event_stamp,
   output      logic [tsmq_pkg::PROC_W-1:0]    rsp_event_proc,
   output      logic                           rsp_stack_valid,
   output      logic [tsmq_pkg::TAG_W-1:0]     rsp_stack_tag,
   output      logic [tsmq_pkg::STAMP_W-1:0]   rsp_stack_stamp,
   output      logic [tsmq_pkg::PROC_W-1:0]    rsp_stack_proc,
   output      logic                           rsp_heads_aligned
);
   import tsmq_pkg::*;

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
   localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(QUEUE_DEPTH);

   // Sequencer states.
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_EXEC  = 2'd1;
   localparam logic [1:0] ST_ALIGN = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [KIND_W-1:0]   kind_ff;
   logic                drop_ff;

   logic [IDX_W-1:0]    ev_head_ff, ev_head_in;
   logic [CNT_W-1:0]    ev_count_ff, ev_count_in;
   logic [IDX_W-1:0]    st_head_ff, st_head_in;
   logic [CNT_W-1:0]    st_count_ff, st_count_in;

   // Queue memories and their registered read data.
   rec_type             ev_mem [QUEUE_DEPTH];
   rec_type             st_mem [QUEUE_DEPTH];
   rec_type             ev_rd_ff, st_rd_ff;
   logic                ev_we, st_we, rd_en;
   logic [IDX_W-1:0]    ev_waddr, st_waddr, ev_raddr, st_raddr;
   logic [SUM_W-1:0]    ev_sum, st_sum;

   // Result of the merge step, waiting for the alignment check.
   logic [STATUS_W-1:0] pend_status_ff;
   logic                pend_ev_valid_ff, pend_st_valid_ff;
   rec_type             pend_ev_ff, pend_st_ff;
   rec_type             pend_ev_in, pend_st_in;

   logic                rsp_valid_ff;
   logic                accept, start, out_load;
   logic                ev_full, st_full, ev_empty, st_empty;
   logic                stamps_equal, ev_older;
   logic                pop_ev, pop_st;
   logic                aligned;

   // Record presented on the request channel.
   function automatic rec_type req_rec_in();
      rec_type r;
      r.stamp   = req_stamp;
      r.proc_id = req_proc_id;
      r.tag     = req_tag;
      return r;
   endfunction

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign start     = accept && (req_kind != KIND_UNUSED);

   assign ev_full  = (ev_count_ff == DEPTH_CNT);
   assign st_full  = (st_count_ff == DEPTH_CNT);
   assign ev_empty = (ev_count_ff == '0);
   assign st_empty = (st_count_ff == '0);

   // Tail slot is head plus count, wrapped once into the queue depth.
   always_comb begin
      ev_sum = SUM_W'(ev_head_ff) + SUM_W'(ev_count_ff);
      if (ev_sum >= DEPTH_SUM) begin
         ev_sum = ev_sum - DEPTH_SUM;
      end
      st_sum = SUM_W'(st_head_ff) + SUM_W'(st_count_ff);
      if (st_sum >= DEPTH_SUM) begin
         st_sum = st_sum - DEPTH_SUM;
      end
   end
   assign ev_waddr = ev_sum[IDX_W-1:0];
   assign st_waddr = st_sum[IDX_W-1:0];

   // Pushes write in the accept cycle when the target queue has room.
   assign ev_we = start && (req_kind == KIND_PUSH_EVENT) && !ev_full;
   assign st_we = start && (req_kind == KIND_PUSH_STACK) && !st_full;

   // Merge decision on the current head records.
   assign stamps_equal = (ev_rd_ff.stamp == st_rd_ff.stamp);
   assign ev_older     = (ev_rd_ff.stamp < st_rd_ff.stamp);

   always_comb begin
      pop_ev = 1'b0;
      pop_st = 1'b0;
      if ((state_ff == ST_EXEC) && (kind_ff == KIND_PULL)) begin
         if (ev_empty) begin
            pop_st = !st_empty;
         end else if (st_empty) begin
            pop_ev = 1'b1;
         end else if (stamps_equal) begin
            pop_ev = 1'b1;
            pop_st = 1'b1;
         end else begin
            pop_ev = ev_older;
            pop_st = !ev_older;
         end
      end
   end

   // Head and count updates for pushes and pops.
   always_comb begin
      ev_head_in  = ev_head_ff;
      st_head_in  = st_head_ff;
      ev_count_in = ev_count_ff;
      st_count_in = st_count_ff;
      if (ev_we) begin
         ev_count_in = ev_count_ff + CNT_W'(1);
      end
      if (st_we) begin
         st_count_in = st_count_ff + CNT_W'(1);
      end
      if (pop_ev) begin
         ev_head_in  = (ev_head_ff == LAST_IDX) ? '0 : ev_head_ff + IDX_W'(1);
         ev_count_in = ev_count_ff - CNT_W'(1);
      end
      if (pop_st) begin
         st_head_in  = (st_head_ff == LAST_IDX) ? '0 : st_head_ff + IDX_W'(1);
         st_count_in = st_count_ff - CNT_W'(1);
      end
   end

   // Heads are read on accept for the merge, and again after the step.
   assign rd_en    = start || (state_ff == ST_EXEC);
   assign ev_raddr = ev_head_in;
   assign st_raddr = st_head_in;

   always_ff @(posedge clock) begin
      if (ev_we) begin
         ev_mem[ev_waddr] <= req_rec_in();
      end
      if (rd_en) begin
         ev_rd_ff <= ev_mem[ev_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         st_mem[st_waddr] <= req_rec_in();
      end
      if (rd_en) begin
         st_rd_ff <= st_mem[st_raddr];
      end
   end

   // Popped records; a paired event takes the call stack's process id.
   always_comb begin
      pend_ev_in = '0;
      pend_st_in = '0;
      if (pop_ev) begin
         pend_ev_in.stamp   = ev_rd_ff.stamp;
         pend_ev_in.tag     = ev_rd_ff.tag;
         pend_ev_in.proc_id = pop_st ? st_rd_ff.proc_id : ev_rd_ff.proc_id;
      end
      if (pop_st) begin
         pend_st_in = st_rd_ff;
      end
   end

   // Alignment of the heads left after the step.
   assign aligned  = !ev_empty && !st_empty && stamps_equal;
   assign out_load = (state_ff == ST_ALIGN) && (!rsp_valid_ff || !rsp_stall);

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_ALIGN;
         end
         ST_ALIGN: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ev_head_ff   <= '0;
         ev_count_ff  <= '0;
         st_head_ff   <= '0;
         st_count_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         ev_head_ff  <= ev_head_in;
         ev_count_ff <= ev_count_in;
         st_head_ff  <= st_head_in;
         st_count_ff <= st_count_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Captured request and the pending merge result.
   always_ff @(posedge clock) begin
      if (start) begin
         kind_ff    <= req_kind;
         drop_ff    <= ((req_kind == KIND_PUSH_EVENT) && ev_full) ||
                       ((req_kind == KIND_PUSH_STACK) && st_full);
      end
      if (state_ff == ST_EXEC) begin
         pend_ev_valid_ff <= pop_ev;
         pend_st_valid_ff <= pop_st;
         pend_ev_ff       <= pend_ev_in;
         pend_st_ff       <= pend_st_in;
         if (kind_ff == KIND_PULL) begin
            pend_status_ff <= (ev_empty && st_empty) ? STATUS_PULL_DONE
                                                     : STATUS_PULL_DATA;
         end else begin
            pend_status_ff <= drop_ff ? STATUS_PUSH_DROP : STATUS_PUSH_OK;
         end
      end
   end

   // Response output register.
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_status        <= pend_status_ff;
         rsp_event_valid   <= pend_ev_valid_ff;
         rsp_event_tag     <= pend_ev_ff.tag;
         rsp_event_stamp   <= pend_ev_ff.stamp;
         rsp_event_proc    <= pend_ev_ff.proc_id;
         rsp_stack_valid   <= pend_st_valid_ff;
         rsp_stack_tag     <= pend_st_ff.tag;
         rsp_stack_stamp   <= pend_st_ff.stamp;
         rsp_stack_proc    <= pend_st_ff.proc_id;
         rsp_heads_aligned <= aligned;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule : timestamp_merge_two_queues_unit
`default_nettype wire

[bench/tsmq_merge_checker.sv]
// ============================================================================
// Timestamp merge checker
// Watches the request and response channels of the two-queue merge unit.
// Keeps its own event and call stack queues, predicts the response of every
// accepted push or pull, and compares each accepted response with the oldest
// prediction, field by field.
// ============================================================================
module tsmq_merge_checker #(
   parameter int QUEUE_DEPTH = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [tsmq_pkg::KIND_W-1:0]   req_kind,
   input  logic [tsmq_pkg::STAMP_W-1:0]  req_stamp,
   input  logic [tsmq_pkg::PROC_W-1:0]   req_proc_id,
   input  logic [tsmq_pkg::TAG_W-1:0]    req_tag,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [tsmq_pkg::STATUS_W-1:0] rsp_status,
   input  logic                          rsp_event_valid,
   input  logic [tsmq_pkg::TAG_W-1:0]    rsp_event_tag,
   input  logic [tsmq_pkg::STAMP_W-1:0]  rsp_event_stamp,
   input  logic [tsmq_pkg::PROC_W-1:0]   rsp_event_proc,
   input  logic                          rsp_stack_valid,
   input  logic [tsmq_pkg::TAG_W-1:0]    rsp_stack_tag,
   input  logic [tsmq_pkg::STAMP_W-1:0]  rsp_stack_stamp,
   input  logic [tsmq_pkg::PROC_W-1:0]   rsp_stack_proc,
   input  logic                          rsp_heads_aligned,
   output int                            error_count,
   output int                            pending_count,
   output int                            checked_count,
   output int                            paired_count,
   output int                            drop_count,
   output int                            empty_pull_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import tsmq_pkg::*;

   // One predicted response, laid out like the response channel.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                event_valid;
      logic [TAG_W-1:0]    event_tag;
      logic [STAMP_W-1:0]  event_stamp;
      logic [PROC_W-1:0]   event_proc;
      logic                stack_valid;
      logic [TAG_W-1:0]    stack_tag;
      logic [STAMP_W-1:0]  stack_stamp;
      logic [PROC_W-1:0]   stack_proc;
      logic                heads_aligned;
   } merge_result_type;

   rec_type          event_fifo[$];
   rec_type          stack_fifo[$];
   merge_result_type merge_outcomes[$];

   int errors  = 0;
   int pending = 0;
   int checked = 0;
   int pairs   = 0;
   int drops   = 0;
   int empties = 0;

   assign error_count      = errors;
   assign pending_count    = pending;
   assign checked_count    = checked;
   assign paired_count     = pairs;
   assign drop_count       = drops;
   assign empty_pull_count = empties;

   // Apply one push or pull to the mirrored queues and return its response.
   function automatic merge_result_type merge_step(input logic [KIND_W-1:0] kind,
                                                   input logic [STAMP_W-1:0] stamp,
                                                   input logic [PROC_W-1:0] proc_id,
                                                   input logic [TAG_W-1:0] tag);
      merge_result_type r;
      rec_type          rec;
      rec_type          ev;
      rec_type          st;
      logic             take_ev;
      logic             take_st;
      r = '0;
      rec.stamp   = stamp;
      rec.proc_id = proc_id;
      rec.tag     = tag;
      case (kind)
         KIND_PUSH_EVENT: begin
            if (event_fifo.size() >= QUEUE_DEPTH) begin
               r.status = STATUS_PUSH_DROP;
               drops++;
            end else begin
               event_fifo.insert(event_fifo.size(), rec);
               r.status = STATUS_PUSH_OK;
            end
         end
         KIND_PUSH_STACK: begin
            if (stack_fifo.size() >= QUEUE_DEPTH) begin
               r.status = STATUS_PUSH_DROP;
               drops++;
            end else begin
               stack_fifo.insert(stack_fifo.size(), rec);
               r.status = STATUS_PUSH_OK;
            end
         end
         KIND_PULL: begin
            if (event_fifo.size() == 0 && stack_fifo.size() == 0) begin
               r.status = STATUS_PULL_DONE;
               empties++;
            end else begin
               r.status = STATUS_PULL_DATA;
               // The older head leaves; equal stamps leave together.
               take_ev = stack_fifo.size() == 0 ||
                         (event_fifo.size() != 0 && event_fifo[0].stamp <= stack_fifo[0].stamp);
               take_st = event_fifo.size() == 0 ||
                         (stack_fifo.size() != 0 && stack_fifo[0].stamp <= event_fifo[0].stamp);
               if (take_st) begin
                  st = stack_fifo[0];
                  stack_fifo.delete(0);
                  r.stack_valid = 1'b1;
                  r.stack_tag   = st.tag;
                  r.stack_stamp = st.stamp;
                  r.stack_proc  = st.proc_id;
               end
               if (take_ev) begin
                  ev = event_fifo[0];
                  event_fifo.delete(0);
                  r.event_valid = 1'b1;
                  r.event_tag   = ev.tag;
                  r.event_stamp = ev.stamp;
                  // A paired event takes the process id of its call stack.
                  r.event_proc  = take_st ? st.proc_id : ev.proc_id;
               end
               if (take_ev && take_st) begin
                  pairs++;
               end
            end
         end
         default: begin
         end
      endcase
      r.heads_aligned = event_fifo.size() != 0 && stack_fifo.size() != 0 &&
                        event_fifo[0].stamp == stack_fifo[0].stamp;
      return r;
   endfunction

   task automatic check_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: rsp_%s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
   endtask

   // Responses are matched before the same edge's request is predicted, so a
   // response can never pair with a request taken at the same edge.
   always @(posedge clock) begin
      merge_result_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (merge_outcomes.size() == 0) begin
               errors++;
               $display("%0t: response transaction with nothing expected, status %0h",
                        $time, rsp_status);
            end else begin
               want = merge_outcomes[0];
               merge_outcomes.delete(0);
               checked++;
               check_field("status", 64'(want.status), 64'(rsp_status));
               check_field("event_valid", 64'(want.event_valid), 64'(rsp_event_valid));
               check_field("event_tag", 64'(want.event_tag), 64'(rsp_event_tag));
               check_field("event_stamp", want.event_stamp, rsp_event_stamp);
               check_field("event_proc", 64'(want.event_proc), 64'(rsp_event_proc));
               check_field("stack_valid", 64'(want.stack_valid), 64'(rsp_stack_valid));
               check_field("stack_tag", 64'(want.stack_tag), 64'(rsp_stack_tag));
               check_field("stack_stamp", want.stack_stamp, rsp_stack_stamp);
               check_field("stack_proc", 64'(want.stack_proc), 64'(rsp_stack_proc));
               check_field("heads_aligned", 64'(want.heads_aligned),
                           64'(rsp_heads_aligned));
            end
         end
         if (req_valid && !req_stall && req_kind != KIND_UNUSED) begin
            merge_outcomes.insert(merge_outcomes.size(),
                                  merge_step(req_kind, req_stamp, req_proc_id, req_tag));
         end
         pending = merge_outcomes.size();
      end
   end

endmodule : tsmq_merge_checker

[bench/tb_timestamp_merge_two_queues_unit.sv]
// ============================================================================
// Testbench for the two-queue timestamp merge unit
// Drives directed corner cases, then random trace segments, a queue fill to
// overflow and noise, with random gaps on requests and random response
// stalls. A separate checker predicts and compares every response.
// ============================================================================
module tb_timestamp_merge_two_queues_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import tsmq_pkg::*;

   localparam int DEPTH        = 64;
   localparam int TARGET_ITEMS = 650;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int DRAIN_CYCLES = 12;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [KIND_W-1:0]   req_kind = KIND_PULL;
   logic [STAMP_W-1:0]  req_stamp = '0;
   logic [PROC_W-1:0]   req_proc_id = '0;
   logic [TAG_W-1:0]    req_tag = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_event_valid;
   logic [TAG_W-1:0]    rsp_event_tag;
   logic [STAMP_W-1:0]  rsp_event_stamp;
   logic [PROC_W-1:0]   rsp_event_proc;
   logic                rsp_stack_valid;
   logic [TAG_W-1:0]    rsp_stack_tag;
   logic [STAMP_W-1:0]  rsp_stack_stamp;
   logic [PROC_W-1:0]   rsp_stack_proc;
   logic                rsp_heads_aligned;

   int error_count;
   int pending_count;
   int checked_count;
   int paired_count;
   int drop_count;
   int empty_pull_count;

   int sent_count    = 0;
   int ignored_count = 0;
   int quiet_left    = 0;
   int cycle_count   = 0;
   bit fill_done     = 1'b0;

   timestamp_merge_two_queues_unit #(.QUEUE_DEPTH(DEPTH)) DUT (.*);

   tsmq_merge_checker #(.QUEUE_DEPTH(DEPTH)) merge_check (.*);

   // Free-running clock, 8 ns period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, pending_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Response stalls: runs of no stall, short stalls and a few long ones.
   initial begin
      int r;
      int span;
      @(posedge clock);
      forever begin
         r = $urandom_range(0, 99);
         if (r < 35) begin
            rsp_stall <= 1'b0;
            span = $urandom_range(1, 40);
         end else if (r < 55) begin
            rsp_stall <= 1'b0;
            span = $urandom_range(1, 4);
         end else if (r < 92) begin
            rsp_stall <= 1'b1;
            span = $urandom_range(1, 3);
         end else begin
            rsp_stall <= 1'b1;
            span = $urandom_range(5, 40);
         end
         repeat (span) @(posedge clock);
      end
   end

   // Idle cycles before a request: mostly none or short, now and then long,
   // with occasional quiet stretches of back-to-back requests.
   function automatic int pick_gap();
      int r;
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         quiet_left = $urandom_range(20, 60);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   function automatic logic [STAMP_W-1:0] pick_stamp();
      case ($urandom_range(0, 9))
         0:       return '1;
         1:       return '0;
         2, 3:    return STAMP_W'($urandom_range(0, 7));
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   // Present one request and hold it until the unit takes it.
   task automatic send_request(input logic [KIND_W-1:0] kind,
                               input logic [STAMP_W-1:0] stamp,
                               input logic [PROC_W-1:0] proc_id,
                               input logic [TAG_W-1:0] tag);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_kind    <= kind;
      req_stamp   <= stamp;
      req_proc_id <= proc_id;
      req_tag     <= tag;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (kind == KIND_UNUSED) ignored_count++;
      else sent_count++;
   endtask

   task automatic send_pull();
      send_request(KIND_PULL, pick_stamp(), $urandom(), TAG_W'($urandom()));
   endtask

   // A well-formed trace segment: records with rising stamps, most of them
   // present in both queues, pushed in mixed order and then merged out.
   task automatic send_trace_segment();
      int                 n;
      int                 c;
      int                 pushes;
      int                 pulls;
      logic [STAMP_W-1:0] now_stamp;
      logic [STAMP_W-1:0] next_stamp;
      logic [STAMP_W-1:0] ev_stamps[$];
      logic [STAMP_W-1:0] st_stamps[$];
      n = $urandom_range(1, 8);
      now_stamp = pick_stamp();
      for (int i = 0; i < n; i++) begin
         now_stamp += STAMP_W'($urandom_range(0, 3));
         c = $urandom_range(0, 9);
         if (c < 7 || c == 7) ev_stamps.insert(ev_stamps.size(), now_stamp);
         if (c < 7 || c == 8) st_stamps.insert(st_stamps.size(), now_stamp);
         if (c == 9) st_stamps.insert(st_stamps.size(), now_stamp + STAMP_W'(1));
      end
      pushes = ev_stamps.size() + st_stamps.size();
      while (ev_stamps.size() != 0 || st_stamps.size() != 0) begin
         if (st_stamps.size() == 0 || (ev_stamps.size() != 0 && $urandom_range(0, 1) == 1)) begin
            next_stamp = ev_stamps[0];
            ev_stamps.delete(0);
            send_request(KIND_PUSH_EVENT, next_stamp, $urandom(), TAG_W'($urandom()));
         end else begin
            next_stamp = st_stamps[0];
            st_stamps.delete(0);
            send_request(KIND_PUSH_STACK, next_stamp, $urandom(), TAG_W'($urandom()));
         end
      end
      // Sometimes leave records behind so the queue depth wanders.
      pulls = ($urandom_range(0, 9) < 3) ? $urandom_range(pushes / 2, pushes) : pushes + 1;
      repeat (pulls) send_pull();
   endtask

   // Fill both queues past their depth so pushes get dropped, then drain.
   task automatic send_fill_burst();
      logic [STAMP_W-1:0] now_stamp;
      now_stamp = pick_stamp();
      for (int i = 0; i < DEPTH + 3; i++) begin
         now_stamp += STAMP_W'($urandom_range(1, 2));
         send_request(KIND_PUSH_EVENT, now_stamp, $urandom(), TAG_W'($urandom()));
         send_request(KIND_PUSH_STACK,
                      ($urandom_range(0, 7) == 0) ? now_stamp + STAMP_W'(1) : now_stamp,
                      $urandom(), TAG_W'($urandom()));
      end
      repeat (DEPTH + 8) send_pull();
   endtask

   // Unstructured requests of every kind, including the unused one.
   task automatic send_noise_burst();
      repeat ($urandom_range(1, 10)) begin
         send_request(KIND_W'($urandom_range(0, 3)), pick_stamp(), $urandom(),
                      TAG_W'($urandom()));
      end
   endtask

   // Main stimulus.
   initial begin
      int r;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Pull with both queues empty, and the unused kind.
      send_request(KIND_PULL, '1, '1, '1);
      send_request(KIND_UNUSED, '1, '1, '1);
      send_request(KIND_UNUSED, '0, '0, '0);
      // Equal stamps at the top of the range: paired pull, proc id from the stack.
      send_request(KIND_PUSH_EVENT, '1, '1, '1);
      send_request(KIND_PUSH_STACK, '1, '0, '0);
      send_request(KIND_PULL, '0, '0, '0);
      // Event alone with all-zero fields, then a call stack alone with all ones.
      send_request(KIND_PUSH_EVENT, '0, '0, '0);
      send_request(KIND_PULL, '0, '0, '0);
      send_request(KIND_PUSH_STACK, '1, '1, '1);
      send_request(KIND_PULL, '1, '1, '1);
      // Stamps differing in the top bit, each side being the older once.
      send_request(KIND_PUSH_EVENT, 64'h8000_0000_0000_0000, 32'h1234_5678, 16'hA5A5);
      send_request(KIND_PUSH_STACK, 64'h7FFF_FFFF_FFFF_FFFF, 32'h8765_4321, 16'h5A5A);
      send_request(KIND_PULL, '0, '0, '0);
      send_request(KIND_PULL, '0, '0, '0);
      send_request(KIND_PUSH_EVENT, 64'h7FFF_FFFF_FFFF_FFFF, 32'hFFFF_0000, 16'h00FF);
      send_request(KIND_PUSH_STACK, 64'h8000_0000_0000_0000, 32'h0000_FFFF, 16'hFF00);
      send_request(KIND_PULL, '0, '0, '0);
      send_request(KIND_PULL, '0, '0, '0);
      send_request(KIND_PULL, '0, '0, '0);

      // Random part: mostly trace segments, some noise, one overflow fill.
      while (sent_count < TARGET_ITEMS) begin
         r = $urandom_range(0, 19);
         if (!fill_done && (r == 0 || sent_count > TARGET_ITEMS / 2)) begin
            send_fill_burst();
            fill_done = 1'b1;
         end else if (r < 5) begin
            send_noise_burst();
         end else begin
            send_trace_segment();
         end
      end
      req_valid <= 1'b0;

      // Let the checker record the last request, wait for every outstanding
      // response to come back, then settle.
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d push and pull transactions plus %0d ignored ones; %0d responses checked.",
               sent_count, ignored_count, checked_count);
      $display("Saw %0d paired pulls, %0d dropped pushes and %0d pulls on empty queues.",
               paired_count, drop_count, empty_pull_count);
      if (error_count == 0 && pending_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule : tb_timestamp_merge_two_queues_unit

[timestamp_merge_two_queues_unit.f]
design/tsmq_pkg.sv
design/timestamp_merge_two_queues_unit.sv
bench/tsmq_merge_checker.sv
bench/tb_timestamp_merge_two_queues_unit.sv
